FILE: design/mrc_pkg.sv
// package for the mixed-radix odometer counter: sizes, command and microcode types,
// the microcode rom and the radix clamp helper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrc_pkg;

    // digit count and field widths
    localparam int DIGITS    = 4;
    localparam int NREG      = 4;
    localparam int RADIX_W   = 9;
    localparam int DIGIT_W   = 8;
    localparam int INDEX_W   = 32;
    localparam int CMD_W     = 2;
    localparam int CFG_AW    = 2;
    localparam int CNT_W     = $clog2(DIGITS + 1);
    localparam int DIV_CNT_W = $clog2(INDEX_W + 1);
    localparam int PC_W      = 4;

    // stream payload widths, padded to whole bytes
    localparam int S_USED_W   = CMD_W + INDEX_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;
    localparam int M_USED_W   = 4 * DIGIT_W + INDEX_W + 2;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(256);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_LOAD  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    // datapath operation of one microcode step
    typedef enum logic [3:0] {
        DP_NOP,
        DP_SET_UNDEF,
        DP_ZERO_ALL,
        DP_IDX_CLR,
        DP_INC_DIGIT,
        DP_SUM_INIT,
        DP_SUM_ACC,
        DP_SUM_MUL,
        DP_EMIT,
        DP_LOAD_V,
        DP_DIV_START,
        DP_DIV_STORE
    } dp_op_t;

    // how the step counter moves on
    typedef enum logic [3:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT_IN,
        C_DISPATCH,
        C_IF_DEF,
        C_IF_CARRY_MORE,
        C_IF_NOT_LAST,
        C_WAIT_DIV,
        C_WAIT_OUT
    } cond_t;

    typedef struct packed {
        dp_op_t          op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic undef;
        logic carry;
        logic last;
        logic div_busy;
    } dp_stat_t;

    // program labels
    localparam logic [PC_W-1:0] PC_IDLE      = PC_W'(0);
    localparam logic [PC_W-1:0] PC_DISPATCH  = PC_W'(1);
    localparam logic [PC_W-1:0] PC_CLEAR     = PC_W'(2);
    localparam logic [PC_W-1:0] PC_STEP      = PC_W'(3);
    localparam logic [PC_W-1:0] PC_ZERO      = PC_W'(4);
    localparam logic [PC_W-1:0] PC_INC       = PC_W'(5);
    localparam logic [PC_W-1:0] PC_SUM_INIT  = PC_W'(6);
    localparam logic [PC_W-1:0] PC_SUM_ACC   = PC_W'(7);
    localparam logic [PC_W-1:0] PC_SUM_MUL   = PC_W'(8);
    localparam logic [PC_W-1:0] PC_EMIT      = PC_W'(9);
    localparam logic [PC_W-1:0] PC_LOAD      = PC_W'(10);
    localparam logic [PC_W-1:0] PC_DIV_START = PC_W'(11);
    localparam logic [PC_W-1:0] PC_DIV_WAIT  = PC_W'(12);
    localparam logic [PC_W-1:0] PC_DIV_STORE = PC_W'(13);
    localparam logic [PC_W-1:0] PC_LOAD_END  = PC_W'(14);

    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        case (pc)
            PC_IDLE:      w = '{op: DP_NOP,       cond: C_WAIT_IN,       target: PC_IDLE};
            PC_DISPATCH:  w = '{op: DP_NOP,       cond: C_DISPATCH,      target: PC_IDLE};
            PC_CLEAR:     w = '{op: DP_SET_UNDEF, cond: C_JUMP,          target: PC_SUM_INIT};
            PC_STEP:      w = '{op: DP_IDX_CLR,   cond: C_IF_DEF,        target: PC_INC};
            PC_ZERO:      w = '{op: DP_ZERO_ALL,  cond: C_JUMP,          target: PC_SUM_INIT};
            PC_INC:       w = '{op: DP_INC_DIGIT, cond: C_IF_CARRY_MORE, target: PC_INC};
            PC_SUM_INIT:  w = '{op: DP_SUM_INIT,  cond: C_NEXT,          target: PC_IDLE};
            PC_SUM_ACC:   w = '{op: DP_SUM_ACC,   cond: C_NEXT,          target: PC_IDLE};
            PC_SUM_MUL:   w = '{op: DP_SUM_MUL,   cond: C_IF_NOT_LAST,   target: PC_SUM_ACC};
            PC_EMIT:      w = '{op: DP_EMIT,      cond: C_WAIT_OUT,      target: PC_IDLE};
            PC_LOAD:      w = '{op: DP_LOAD_V,    cond: C_NEXT,          target: PC_IDLE};
            PC_DIV_START: w = '{op: DP_DIV_START, cond: C_NEXT,          target: PC_IDLE};
            PC_DIV_WAIT:  w = '{op: DP_NOP,       cond: C_WAIT_DIV,      target: PC_IDLE};
            PC_DIV_STORE: w = '{op: DP_DIV_STORE, cond: C_IF_NOT_LAST,   target: PC_DIV_START};
            PC_LOAD_END:  w = '{op: DP_NOP,       cond: C_JUMP,          target: PC_SUM_INIT};
            default:      w = '{op: DP_NOP,       cond: C_JUMP,          target: PC_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [PC_W-1:0] dispatch_target(input cmd_t cmd);
        logic [PC_W-1:0] t;
        unique case (cmd)
            CMD_CLEAR: t = PC_CLEAR;
            CMD_STEP:  t = PC_STEP;
            CMD_LOAD:  t = PC_LOAD;
            CMD_QUERY: t = PC_SUM_INIT;
            default:   t = PC_IDLE;
        endcase
        return t;
    endfunction

    // zero acts as one, anything above 256 acts as 256
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] raw);
        logic [RADIX_W-1:0] r;
        if (raw == '0) begin
            r = RADIX_W'(1);
        end else if (raw > RADIX_MAX) begin
            r = RADIX_MAX;
        end else begin
            r = raw;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/mrc_div.sv
// restoring divider, one quotient bit per cycle, for splitting an index by a radix
// depends on mrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrc_div import mrc_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [INDEX_W-1:0] dividend,
    input  wire logic [RADIX_W-1:0] divisor,
    output logic                    busy,
    output logic [INDEX_W-1:0]      quotient,
    output logic [RADIX_W-1:0]      remainder
);

    logic [INDEX_W-1:0]   quo_reg;
    logic [RADIX_W-1:0]   rem_reg;
    logic [RADIX_W-1:0]   dsr_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    logic [RADIX_W:0]     shifted;
    logic [RADIX_W:0]     diff;
    logic                 fits;

    assign shifted = {rem_reg, quo_reg[INDEX_W-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(INDEX_W);
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[INDEX_W-2:0], fits};
            rem_reg <= fits ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: design/mrc_dpath.sv
// datapath: radix registers, digit store, undefined flag, shared multiplier for the
// linear index and the divider used by load
// depends on mrc_pkg and mrc_div
`timescale 1ns / 1ps
`default_nettype none

module mrc_dpath import mrc_pkg::*; (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [CFG_AW-1:0]               cfg_addr,
    input  wire logic [RADIX_W-1:0]              cfg_wdata,
    input  wire dp_op_t                          op,
    input  wire logic [INDEX_W-1:0]              load_value,
    output logic [DIGITS-1:0][DIGIT_W-1:0]       digits,
    output logic [INDEX_W-1:0]                   lin_index,
    output logic                                 below,
    output dp_stat_t                             stat
);

    logic [RADIX_W-1:0]              radix_reg [NREG];
    logic [DIGITS-1:0][DIGIT_W-1:0]  digit_reg, digit_next;
    logic                            undef_reg, undef_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic [INDEX_W-1:0]              acc_reg, acc_next;
    logic [INDEX_W-1:0]              mult_reg, mult_next;
    logic [INDEX_W-1:0]              val_reg, val_next;
    logic                            below_reg, below_next;

    logic [DIGIT_W-1:0]              cur_digit;
    logic [RADIX_W-1:0]              cur_radix;
    logic [RADIX_W-1:0]              radix_m1;
    logic                            at_max;
    logic [RADIX_W-1:0]              mul_opnd;
    logic [INDEX_W+RADIX_W-1:0]      product;
    logic [DIGIT_W-1:0]              wr_digit;
    logic                            wr_en;

    logic                            div_busy;
    logic [INDEX_W-1:0]              div_quo;
    logic [RADIX_W-1:0]              div_rem;

    // digit and radix at the current index; digits past the registers have radix one
    always_comb begin
        cur_digit = '0;
        cur_radix = RADIX_W'(1);
        for (int k = 0; k < DIGITS; k++) begin
            if (32'(idx_reg) == k) begin
                cur_digit = digit_reg[k];
            end
        end
        for (int k = 0; k < NREG; k++) begin
            if (32'(idx_reg) == k) begin
                cur_radix = eff_radix(radix_reg[k]);
            end
        end
    end

    assign radix_m1 = cur_radix - RADIX_W'(1);
    assign at_max   = {1'b0, cur_digit} >= radix_m1;
    assign mul_opnd = (op == DP_SUM_MUL) ? cur_radix : {1'b0, cur_digit};
    assign product  = mult_reg * mul_opnd;

    mrc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (op == DP_DIV_START),
        .dividend  (val_reg),
        .divisor   (cur_radix),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    always_comb begin
        digit_next = digit_reg;
        undef_next = undef_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        mult_next  = mult_reg;
        val_next   = val_reg;
        below_next = below_reg;
        wr_en      = 1'b0;
        wr_digit   = '0;
        unique case (op)
            DP_SET_UNDEF: undef_next = 1'b1;
            DP_ZERO_ALL: begin
                digit_next = '0;
                undef_next = 1'b0;
            end
            DP_IDX_CLR: idx_next = '0;
            DP_INC_DIGIT: begin
                wr_en    = 1'b1;
                wr_digit = at_max ? '0 : cur_digit + DIGIT_W'(1);
                idx_next = idx_reg + CNT_W'(1);
            end
            DP_SUM_INIT: begin
                acc_next   = '0;
                mult_next  = INDEX_W'(1);
                below_next = 1'b0;
                idx_next   = '0;
            end
            DP_SUM_ACC: begin
                acc_next   = acc_reg + product[INDEX_W-1:0];
                below_next = below_reg | !at_max;
            end
            DP_SUM_MUL: begin
                mult_next = product[INDEX_W-1:0];
                idx_next  = idx_reg + CNT_W'(1);
            end
            DP_LOAD_V: begin
                val_next   = load_value;
                undef_next = 1'b0;
                idx_next   = '0;
            end
            DP_DIV_STORE: begin
                wr_en    = 1'b1;
                wr_digit = div_rem[DIGIT_W-1:0];
                val_next = div_quo;
                idx_next = idx_reg + CNT_W'(1);
            end
            DP_NOP, DP_EMIT, DP_DIV_START: ;
            default: ;
        endcase
        if (wr_en) begin
            for (int k = 0; k < DIGITS; k++) begin
                if (32'(idx_reg) == k) begin
                    digit_next[k] = wr_digit;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NREG; k++) begin
                radix_reg[k] <= RADIX_RESET;
            end
            digit_reg <= '0;
            undef_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                radix_reg[cfg_addr] <= cfg_wdata;
            end
            digit_reg <= digit_next;
            undef_reg <= undef_next;
            idx_reg   <= idx_next;
        end
        acc_reg   <= acc_next;
        mult_reg  <= mult_next;
        val_reg   <= val_next;
        below_reg <= below_next;
    end

    assign digits        = digit_reg;
    assign lin_index     = acc_reg;
    assign below         = below_reg;
    assign stat.undef    = undef_reg;
    assign stat.carry    = at_max;
    assign stat.last     = (idx_reg == CNT_W'(DIGITS - 1));
    assign stat.div_busy = div_busy;

endmodule

`default_nettype wire

FILE: design/mrc_seq.sv
// microcode sequencer: step counter, control word rom and conditional jumps
// depends on mrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrc_seq import mrc_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_fire,
    input  wire logic     out_block,
    input  wire cmd_t     cmd,
    input  wire dp_stat_t stat,
    output ctrl_word_t    ctrl
);

    logic [PC_W-1:0] pc_reg, pc_next, pc_inc;

    assign ctrl   = ucode_rom(pc_reg);
    assign pc_inc = pc_reg + PC_W'(1);

    always_comb begin
        unique case (ctrl.cond)
            C_NEXT:          pc_next = pc_inc;
            C_JUMP:          pc_next = ctrl.target;
            C_WAIT_IN:       pc_next = in_fire ? pc_inc : pc_reg;
            C_DISPATCH:      pc_next = dispatch_target(cmd);
            C_IF_DEF:        pc_next = !stat.undef ? ctrl.target : pc_inc;
            C_IF_CARRY_MORE: pc_next = (stat.carry && !stat.last) ? ctrl.target : pc_inc;
            C_IF_NOT_LAST:   pc_next = !stat.last ? ctrl.target : pc_inc;
            C_WAIT_DIV:      pc_next = stat.div_busy ? pc_reg : pc_inc;
            C_WAIT_OUT:      pc_next = out_block ? pc_reg : ctrl.target;
            default:         pc_next = PC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/mixed_radix_odometer_counter.sv
// mixed-radix odometer counter, top level: stream ports, command capture, result register
// load splits the index with the one-bit-per-cycle divider, shared by all digits, one digit after another
// one command at a time; the next input is taken once the result sits in the output register
// reset (aresetn low, synchronous): radices 2, digits zero, not undefined, outputs empty
// depends on mrc_pkg, mrc_seq, mrc_dpath, mrc_div
`timescale 1ns / 1ps
`default_nettype none

module mixed_radix_odometer_counter import mrc_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // configuration writes, one radix register per index
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_AW-1:0]    cfg_addr,
    input  wire logic [RADIX_W-1:0]   cfg_wdata,

    // command input
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // command[1:0], index_value[33:2], zero pad

    // result output
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata    // digit_0..digit_3[31:0], linear_index[63:32],
                                                 // has_next[64], is_undefined[65], zero pad
);

    ctrl_word_t                     ctrl;
    dp_stat_t                       stat;
    logic                           in_fire;
    logic                           out_block;
    logic                           emit_fire;

    cmd_t                           cmd_reg;
    logic [INDEX_W-1:0]             index_reg;

    logic [DIGITS-1:0][DIGIT_W-1:0] digits;
    logic [INDEX_W-1:0]             lin_index;
    logic                           below;
    logic [3:0][DIGIT_W-1:0]        digit_field;
    logic [M_TDATA_W-1:0]           result;

    logic                           m_tvalid_reg;
    logic [M_TDATA_W-1:0]           m_tdata_reg;

    // the program's idle step is the only one that takes a command
    assign s_tready  = (ctrl.cond == C_WAIT_IN);
    assign in_fire   = s_tvalid && s_tready;

    // output register still holds a result nobody has taken
    assign out_block = m_tvalid_reg && !m_tready;
    assign emit_fire = (ctrl.op == DP_EMIT) && !out_block;

    // command and index are held for the whole run of the program
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg   <= cmd_t'(s_tdata[CMD_W-1:0]);
            index_reg <= s_tdata[CMD_W +: INDEX_W];
        end
    end

    mrc_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .out_block (out_block),
        .cmd       (cmd_reg),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    mrc_dpath u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .op         (ctrl.op),
        .load_value (index_reg),
        .digits     (digits),
        .lin_index  (lin_index),
        .below      (below),
        .stat       (stat)
    );

    // digit fields past the configured digit count read zero
    for (genvar j = 0; j < 4; j++) begin : g_digit_field
        if (j < DIGITS) begin : g_used
            assign digit_field[j] = digits[j];
        end else begin : g_unused
            assign digit_field[j] = '0;
        end
    end

    // while undefined: linear index reads zero and there is always a next value
    always_comb begin
        result = '0;
        result[4*DIGIT_W-1:0]                = digit_field;
        result[4*DIGIT_W +: INDEX_W]         = stat.undef ? '0 : lin_index;
        result[4*DIGIT_W + INDEX_W]          = stat.undef || below;
        result[4*DIGIT_W + INDEX_W + 1]      = stat.undef;
    end

    // result register: loaded on the emit step, cleared when the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
        if (emit_fire) begin
            m_tdata_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTH
    // one command at a time: no transfer right after one was taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_tready)
        else $error("input taken while a command is in progress");

    // an emitted result is presented in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> m_tvalid)
        else $error("emitted result not presented");

    // an undefined result reports index zero and a next value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4*DIGIT_W + INDEX_W + 1]) |->
        (m_tdata[4*DIGIT_W +: INDEX_W] == '0 && m_tdata[4*DIGIT_W + INDEX_W]))
        else $error("undefined result with nonzero index or no next value");

    // the emit step never overwrites a result still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == DP_EMIT && out_block) |=> m_tvalid)
        else $error("pending result lost");
`endif

endmodule

`default_nettype wire
